@@ rtl/lav_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, constants and helpers for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int AXIS_W        = 18;
  // normalized magnitudes carry their top set bit here
  localparam int NORM_TOP      = 29;
  localparam int NORM_W        = NORM_TOP + 1;
  localparam int SUM_W         = 2 * NORM_W + 2;
  localparam int ROOT_STEPS    = SUM_W / 2;
  // root of up to 3 * 2^60 needs one bit per step
  localparam int ROOT_W        = ROOT_STEPS;

  localparam logic signed [63:0] AXIS_MAX  = 64'sd131071;
  localparam logic signed [63:0] AXIS_MIN  = -64'sd131072;
  localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;

  function automatic axis_t clamp_axis(input logic signed [63:0] v);
    axis_t r;
    if (v > AXIS_MAX) r = axis_t'(AXIS_MAX);
    else if (v < AXIS_MIN) r = axis_t'(AXIS_MIN);
    else r = axis_t'(v);
    return r;
  endfunction

  function automatic coord_t sat_coord(input logic signed [63:0] v);
    coord_t r;
    if (v > COORD_MAX) r = coord_t'(COORD_MAX);
    else if (v < COORD_MIN) r = coord_t'(COORD_MIN);
    else r = coord_t'(v);
    return r;
  endfunction

  // round half away from zero, dropping sh fraction bits
  function automatic logic signed [63:0] round_half(input logic signed [63:0] v,
                                                    input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? unsigned'(-v) : unsigned'(v);
    m = (m + (64'(1) << (sh - 1))) >> sh;
    return v[63] ? -signed'(m) : signed'(m);
  endfunction

endpackage
`default_nettype wire

@@ rtl/lav_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: common prescale, sum of squares, one root
// bit per stage, then three restoring dividers at one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IW   = 33,
  parameter int FRAC = lav_pkg::FRAC_BITS_DEF,
  parameter int SW   = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] vec [3],
  input  logic [SW-1:0]        side,
  output logic                 out_valid,
  output logic signed [FRAC+1:0] nvec [3],
  output logic [SW-1:0]        out_side
);

  localparam int OW  = FRAC + 2;
  localparam int QW  = OW;
  localparam int MW  = $clog2(IW);
  localparam int AW  = lav_pkg::NORM_W;
  localparam int XW  = lav_pkg::SUM_W;
  localparam int RSW = XW + 1;
  localparam int LW  = lav_pkg::ROOT_W;
  localparam int NW  = AW + FRAC + 1;
  localparam int NS  = lav_pkg::ROOT_STEPS;

  // stage A: magnitudes
  logic          a_v;
  logic [IW-1:0] a_mag [3];
  logic [2:0]    a_neg;
  logic [IW-1:0] a_or;
  logic [SW-1:0] a_side;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) begin
      a_v <= in_valid;
      for (int i = 0; i < 3; i++) begin
        a_mag[i] <= vec[i][IW-1] ? unsigned'(-vec[i]) : unsigned'(vec[i]);
        a_neg[i] <= vec[i][IW-1];
      end
      a_or   <= (vec[0][IW-1] ? unsigned'(-vec[0]) : unsigned'(vec[0])) |
                (vec[1][IW-1] ? unsigned'(-vec[1]) : unsigned'(vec[1])) |
                (vec[2][IW-1] ? unsigned'(-vec[2]) : unsigned'(vec[2]));
      a_side <= side;
    end
  end

  // stage B: leading one of the largest magnitude
  logic          b_v;
  logic [IW-1:0] b_mag [3];
  logic [2:0]    b_neg;
  logic [MW-1:0] b_msb;
  logic          b_zero;
  logic [SW-1:0] b_side;
  logic [MW-1:0] msb_next;

  always_comb begin
    msb_next = '0;
    for (int b = 0; b < IW; b++) if (a_or[b]) msb_next = MW'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) begin
      b_v    <= a_v;
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_msb  <= msb_next;
      b_zero <= (a_or == '0);
      b_side <= a_side;
    end
  end

  // stage C: common shift so the top bit lands on NORM_TOP
  logic          c_v;
  logic [AW-1:0] c_a [3];
  logic [2:0]    c_neg;
  logic          c_zero;
  logic [SW-1:0] c_side;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) begin
      c_v <= b_v;
      for (int i = 0; i < 3; i++)
        c_a[i] <= AW'({b_mag[i], {(AW-1){1'b0}}} >> b_msb);
      c_neg  <= b_neg;
      c_zero <= b_zero;
      c_side <= b_side;
    end
  end

  // stage D: squares
  logic            d_v;
  logic [2*AW-1:0] d_sq [3];
  logic [AW-1:0]   d_a [3];
  logic [2:0]      d_neg;
  logic            d_zero;
  logic [SW-1:0]   d_side;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) begin
      d_v <= c_v;
      for (int i = 0; i < 3; i++) d_sq[i] <= c_a[i] * c_a[i];
      d_a    <= c_a;
      d_neg  <= c_neg;
      d_zero <= c_zero;
      d_side <= c_side;
    end
  end

  // root pipeline, entry 0 holds the sum of squares
  logic           r_v    [0:NS];
  logic [XW-1:0]  r_x    [0:NS];
  logic [RSW-1:0] r_res  [0:NS];
  logic [AW-1:0]  r_a    [0:NS][3];
  logic [2:0]     r_neg  [0:NS];
  logic           r_zero [0:NS];
  logic [SW-1:0]  r_side [0:NS];

  always_ff @(posedge clk) begin
    if (rst) r_v[0] <= 1'b0;
    else if (en) begin
      r_v[0]    <= d_v;
      r_x[0]    <= XW'(d_sq[0]) + XW'(d_sq[1]) + XW'(d_sq[2]);
      r_res[0]  <= '0;
      r_a[0]    <= d_a;
      r_neg[0]  <= d_neg;
      r_zero[0] <= d_zero;
      r_side[0] <= d_side;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam logic [RSW-1:0] BIT = RSW'(1) << (XW - 2 - 2 * k);
    logic [RSW-1:0] trial;
    assign trial = r_res[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) r_v[k+1] <= 1'b0;
      else if (en) begin
        r_v[k+1] <= r_v[k];
        if ({1'b0, r_x[k]} >= trial) begin
          r_x[k+1]   <= XW'({1'b0, r_x[k]} - trial);
          r_res[k+1] <= (r_res[k] >> 1) + BIT;
        end else begin
          r_x[k+1]   <= r_x[k];
          r_res[k+1] <= r_res[k] >> 1;
        end
        r_a[k+1]    <= r_a[k];
        r_neg[k+1]  <= r_neg[k];
        r_zero[k+1] <= r_zero[k];
        r_side[k+1] <= r_side[k];
      end
    end
  end

  // divider pipeline, entry 0 holds the rounded numerators
  logic          q_v    [0:QW];
  logic [LW-1:0] q_len  [0:QW];
  logic [LW-1:0] q_rem  [0:QW][3];
  logic [QW-1:0] q_lo   [0:QW][3];
  logic [QW-1:0] q_quo  [0:QW][3];
  logic [2:0]    q_neg  [0:QW];
  logic          q_zero [0:QW];
  logic [SW-1:0] q_side [0:QW];
  logic [LW-1:0] root;
  logic [NW-1:0] num [3];

  assign root = r_res[NS][LW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++)
      num[i] = (NW'(r_a[NS][i]) << FRAC) + NW'(root >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) q_v[0] <= 1'b0;
    else if (en) begin
      q_v[0]   <= r_v[NS];
      q_len[0] <= root;
      for (int i = 0; i < 3; i++) begin
        q_rem[0][i] <= LW'(num[i] >> QW);
        q_lo[0][i]  <= num[i][QW-1:0];
        q_quo[0][i] <= '0;
      end
      q_neg[0]  <= r_neg[NS];
      q_zero[0] <= r_zero[NS];
      q_side[0] <= r_side[NS];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [LW:0] t [3];
    always_comb begin
      for (int i = 0; i < 3; i++) t[i] = {q_rem[j][i], q_lo[j][i][QW-1]};
    end
    always_ff @(posedge clk) begin
      if (rst) q_v[j+1] <= 1'b0;
      else if (en) begin
        q_v[j+1]   <= q_v[j];
        q_len[j+1] <= q_len[j];
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, q_len[j]}) begin
            q_rem[j+1][i] <= LW'(t[i] - {1'b0, q_len[j]});
            q_quo[j+1][i] <= {q_quo[j][i][QW-2:0], 1'b1};
          end else begin
            q_rem[j+1][i] <= t[i][LW-1:0];
            q_quo[j+1][i] <= {q_quo[j][i][QW-2:0], 1'b0};
          end
          q_lo[j+1][i] <= q_lo[j][i] << 1;
        end
        q_neg[j+1]  <= q_neg[j];
        q_zero[j+1] <= q_zero[j];
        q_side[j+1] <= q_side[j];
      end
    end
  end

  // output: sign back, zero vector stays zero
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) begin
      out_valid <= q_v[QW];
      for (int i = 0; i < 3; i++) begin
        if (q_zero[QW]) nvec[i] <= '0;
        else if (q_neg[QW][i]) nvec[i] <= -signed'(q_quo[QW][i]);
        else nvec[i] <= signed'(q_quo[QW][i]);
      end
      out_side <= q_side[QW];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lav_xprod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lav_xprod
// Two-stage cross product: registered partial products, then differences.
// ----------------------------------------------------------------------------
module lav_xprod #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [AW-1:0]   a [3],
  input  logic signed [BW-1:0]   b [3],
  input  logic [SW-1:0]          side,
  output logic                   out_valid,
  output logic signed [AW+BW:0]  c [3],
  output logic [SW-1:0]          out_side
);

  localparam int PW = AW + BW;

  logic                p_v;
  logic signed [PW-1:0] p [6];
  logic [SW-1:0]       p_side;

  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) begin
      p_v    <= in_valid;
      p[0]   <= a[1] * b[2];
      p[1]   <= a[2] * b[1];
      p[2]   <= a[2] * b[0];
      p[3]   <= a[0] * b[2];
      p[4]   <= a[0] * b[1];
      p[5]   <= a[1] * b[0];
      p_side <= side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) begin
      out_valid <= p_v;
      for (int i = 0; i < 3; i++)
        c[i] <= (PW+1)'(p[2*i]) - (PW+1)'(p[2*i+1]);
      out_side <= p_side;
    end
  end

endmodule
`default_nettype wire

@@ rtl/look_at_view_matrix_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Left-handed look-at view matrix from eye, target and up, fixed point.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_stall is low and returns one beat per beat,
// in order. The pipeline depth is set by the two normalizers, each with a
// 31-step square root and a divider that resolves one quotient bit per stage.
// The pipeline moves as a whole: when a result is held at the output, in_stall
// rises and every stage holds.
// Degenerate vectors normalize to zero; translation saturates to 32 bits.
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lav_pkg::coord_t      eye_x,
  input  lav_pkg::coord_t      eye_y,
  input  lav_pkg::coord_t      eye_z,
  input  lav_pkg::coord_t      target_x,
  input  lav_pkg::coord_t      target_y,
  input  lav_pkg::coord_t      target_z,
  input  lav_pkg::coord_t      up_x,
  input  lav_pkg::coord_t      up_y,
  input  lav_pkg::coord_t      up_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lav_pkg::axis_t       right_x,
  output lav_pkg::axis_t       right_y,
  output lav_pkg::axis_t       right_z,
  output lav_pkg::axis_t       upaxis_x,
  output lav_pkg::axis_t       upaxis_y,
  output lav_pkg::axis_t       upaxis_z,
  output lav_pkg::axis_t       forward_x,
  output lav_pkg::axis_t       forward_y,
  output lav_pkg::axis_t       forward_z,
  output lav_pkg::coord_t      shift_x,
  output lav_pkg::coord_t      shift_y,
  output lav_pkg::coord_t      shift_z
);

  localparam int CW  = lav_pkg::COORD_W;
  localparam int FW  = FRAC_BITS + 2;
  localparam int EW  = 3 * CW;
  localparam int S1W = 2 * EW;
  localparam int S2W = EW + 3 * FW;
  localparam int S3W = EW + 6 * FW;
  localparam int RRW = CW + FW + 1;
  localparam int UW  = 2 * FW + 1;
  localparam int PW  = lav_pkg::AXIS_W + CW;
  localparam int DW  = PW + 2;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // input and direction stages
  logic            i_v;
  lav_pkg::coord_t i_eye [3];
  lav_pkg::coord_t i_tgt [3];
  lav_pkg::coord_t i_up  [3];

  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (en) begin
      i_v      <= in_valid;
      i_eye[0] <= eye_x;    i_eye[1] <= eye_y;    i_eye[2] <= eye_z;
      i_tgt[0] <= target_x; i_tgt[1] <= target_y; i_tgt[2] <= target_z;
      i_up[0]  <= up_x;     i_up[1]  <= up_y;     i_up[2]  <= up_z;
    end
  end

  logic                t_v;
  logic signed [CW:0]  t_dir [3];
  logic [S1W-1:0]      t_side;

  always_ff @(posedge clk) begin
    if (rst) t_v <= 1'b0;
    else if (en) begin
      t_v <= i_v;
      for (int i = 0; i < 3; i++) t_dir[i] <= (CW+1)'(i_tgt[i]) - (CW+1)'(i_eye[i]);
      t_side <= {i_eye[0], i_eye[1], i_eye[2], i_up[0], i_up[1], i_up[2]};
    end
  end

  // forward axis
  logic                 n1_v;
  logic signed [FW-1:0] n1_f [3];
  logic [S1W-1:0]       n1_side;

  lav_norm #(.IW(CW + 1), .FRAC(FRAC_BITS), .SW(S1W)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(en), .in_valid(t_v), .vec(t_dir), .side(t_side),
    .out_valid(n1_v), .nvec(n1_f), .out_side(n1_side)
  );

  lav_pkg::coord_t n1_up [3];
  assign n1_up[0] = signed'(n1_side[3*CW-1 -: CW]);
  assign n1_up[1] = signed'(n1_side[2*CW-1 -: CW]);
  assign n1_up[2] = signed'(n1_side[CW-1 -: CW]);

  // raw right axis = up x forward
  logic                  x1_v;
  logic signed [RRW-1:0] x1_r [3];
  logic [S2W-1:0]        x1_side;

  lav_xprod #(.AW(CW), .BW(FW), .SW(S2W)) u_xprod_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(n1_v), .a(n1_up), .b(n1_f),
    .side({n1_side[S1W-1 -: EW], n1_f[0], n1_f[1], n1_f[2]}),
    .out_valid(x1_v), .c(x1_r), .out_side(x1_side)
  );

  // right axis
  logic                 n2_v;
  logic signed [FW-1:0] n2_r [3];
  logic [S2W-1:0]       n2_side;

  lav_norm #(.IW(RRW), .FRAC(FRAC_BITS), .SW(S2W)) u_norm_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(x1_v), .vec(x1_r), .side(x1_side),
    .out_valid(n2_v), .nvec(n2_r), .out_side(n2_side)
  );

  logic signed [FW-1:0] n2_f [3];
  assign n2_f[0] = signed'(n2_side[3*FW-1 -: FW]);
  assign n2_f[1] = signed'(n2_side[2*FW-1 -: FW]);
  assign n2_f[2] = signed'(n2_side[FW-1 -: FW]);

  // camera up axis = forward x right
  logic                 x2_v;
  logic signed [UW-1:0] x2_u [3];
  logic [S3W-1:0]       x2_side;

  lav_xprod #(.AW(FW), .BW(FW), .SW(S3W)) u_xprod_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(n2_v), .a(n2_f), .b(n2_r),
    .side({n2_side, n2_r[0], n2_r[1], n2_r[2]}),
    .out_valid(x2_v), .c(x2_u), .out_side(x2_side)
  );

  // round the up axis, clamp all axes; ax[0] right, ax[1] up, ax[2] forward
  logic            k_v;
  lav_pkg::axis_t  k_ax  [3][3];
  lav_pkg::coord_t k_eye [3];

  always_ff @(posedge clk) begin
    if (rst) k_v <= 1'b0;
    else if (en) begin
      k_v <= x2_v;
      for (int i = 0; i < 3; i++) begin
        k_ax[0][i] <= lav_pkg::clamp_axis(
                        64'(signed'(x2_side[(3-i)*FW-1 -: FW])));
        k_ax[1][i] <= lav_pkg::clamp_axis(
                        lav_pkg::round_half(64'(x2_u[i]), FRAC_BITS));
        k_ax[2][i] <= lav_pkg::clamp_axis(
                        64'(signed'(x2_side[(6-i)*FW-1 -: FW])));
        k_eye[i]   <= signed'(x2_side[S3W-1-i*CW -: CW]);
      end
    end
  end

  // dot products with eye
  logic                 m_v;
  logic signed [PW-1:0] m_p  [3][3];
  lav_pkg::axis_t       m_ax [3][3];

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) begin
      m_v <= k_v;
      for (int j = 0; j < 3; j++)
        for (int i = 0; i < 3; i++) m_p[j][i] <= k_ax[j][i] * k_eye[i];
      m_ax <= k_ax;
    end
  end

  logic                 s_v;
  logic signed [DW-1:0] s_dot [3];
  lav_pkg::axis_t       s_ax  [3][3];

  always_ff @(posedge clk) begin
    if (rst) s_v <= 1'b0;
    else if (en) begin
      s_v <= m_v;
      for (int j = 0; j < 3; j++)
        s_dot[j] <= DW'(m_p[j][0]) + DW'(m_p[j][1]) + DW'(m_p[j][2]);
      s_ax <= m_ax;
    end
  end

  // output register
  lav_pkg::coord_t o_shift [3];
  lav_pkg::axis_t  o_ax    [3][3];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) begin
      out_valid <= s_v;
      for (int j = 0; j < 3; j++)
        o_shift[j] <= lav_pkg::sat_coord(
                        -lav_pkg::round_half(64'(s_dot[j]), FRAC_BITS));
      o_ax <= s_ax;
    end
  end

  assign right_x   = o_ax[0][0];
  assign right_y   = o_ax[0][1];
  assign right_z   = o_ax[0][2];
  assign upaxis_x  = o_ax[1][0];
  assign upaxis_y  = o_ax[1][1];
  assign upaxis_z  = o_ax[1][2];
  assign forward_x = o_ax[2][0];
  assign forward_y = o_ax[2][1];
  assign forward_z = o_ax[2][2];
  assign shift_x   = o_shift[0];
  assign shift_y   = o_shift[1];
  assign shift_z   = o_shift[2];

  // eye on target: nothing but zeros comes out
  a_zero_fwd : assert property (@(posedge clk) disable iff (rst)
    out_valid && forward_x == '0 && forward_y == '0 && forward_z == '0
    |-> right_x == '0 && right_y == '0 && right_z == '0 &&
        upaxis_x == '0 && upaxis_y == '0 && upaxis_z == '0 &&
        shift_x == '0 && shift_y == '0 && shift_z == '0)
    else $error("nonzero output with zero forward axis");

  // no right axis means no camera up axis
  a_zero_right : assert property (@(posedge clk) disable iff (rst)
    out_valid && right_x == '0 && right_y == '0 && right_z == '0
    |-> upaxis_x == '0 && upaxis_y == '0 && upaxis_z == '0 && shift_y == '0)
    else $error("nonzero up axis with zero right axis");

  // a held result stays put until it is taken
  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shift_x) &&
      $stable(shift_y) && $stable(shift_z) && $stable(forward_x))
    else $error("held output beat changed");

endmodule
`default_nettype wire
